// File: hdl/msc_pkg.sv
// ----------------------------------------------------------------------------
// msc_pkg
// Shared types, codes and helper functions of the protocol switch controller.
// ----------------------------------------------------------------------------
package msc_pkg;

  // Event selector carried in the input tuser
  localparam logic [3:0] MODE_SCORES     = 4'd0;
  localparam logic [3:0] MODE_LATENCY    = 4'd1;
  localparam logic [3:0] MODE_CTRL       = 4'd2;
  localparam logic [3:0] MODE_HANDOVER   = 4'd3;
  localparam logic [3:0] MODE_APP_DOWN   = 4'd4;
  localparam logic [3:0] MODE_APP_UP     = 4'd5;
  localparam logic [3:0] MODE_MAC_UP     = 4'd6;
  localparam logic [3:0] MODE_FRAME_BYTE = 4'd7;
  localparam logic [3:0] MODE_TICK       = 4'd8;

  // Command codes
  localparam logic [3:0] CMD_INFO_SENT    = 4'd1;
  localparam logic [3:0] CMD_DONE         = 4'd3;
  localparam logic [3:0] CMD_LATENCY_SEND = 4'd4;

  // Destination ports
  localparam logic [3:0] DEST_NONE     = 4'd0;
  localparam logic [3:0] DEST_P1_CTRL  = 4'd1;
  localparam logic [3:0] DEST_P2_CTRL  = 4'd2;
  localparam logic [3:0] DEST_P1_APP   = 4'd3;
  localparam logic [3:0] DEST_P2_APP   = 4'd4;
  localparam logic [3:0] DEST_P1_MAC   = 4'd5;
  localparam logic [3:0] DEST_P2_MAC   = 4'd6;
  localparam logic [3:0] DEST_APP      = 4'd7;
  localparam logic [3:0] DEST_MAC      = 4'd8;
  localparam logic [3:0] DEST_DECISION = 4'd9;

  // Message kinds
  localparam logic [1:0] KIND_PASS      = 2'd0;
  localparam logic [1:0] KIND_SEND_INFO = 2'd1;
  localparam logic [1:0] KIND_STOP      = 2'd2;
  localparam logic [1:0] KIND_ACTIVE    = 2'd3;

  // Protocol numbers
  localparam logic [1:0] PROTO_NONE = 2'd0;
  localparam logic [1:0] PROTO_ONE  = 2'd1;
  localparam logic [1:0] PROTO_TWO  = 2'd2;

  // Frame constants
  localparam logic [7:0]  HEADER_BYTE     = 8'h41;
  localparam logic [7:0]  LATENCY_TAG     = 8'h4C;  // 'L'
  localparam logic [7:0]  PROTO_ONE_CHAR  = 8'h31;  // '1'
  localparam logic [7:0]  PROTO_TWO_CHAR  = 8'h32;  // '2'
  localparam logic [15:0] CRC_POLY        = 16'h8408;
  localparam logic [12:0] MIN_FRAME_LEN   = 13'd11;
  localparam logic [12:0] SHORT_FRAME_LEN = 13'd6;
  localparam logic [11:0] HEADER_POS      = 12'd0;
  localparam logic [11:0] TENTH_POS       = 12'd9;

  localparam logic [15:0] THRESHOLD_RESET = 16'd1280;

  // Configuration register indexes
  localparam logic CFG_COORDINATOR = 1'b0;
  localparam logic CFG_THRESHOLD   = 1'b1;

  typedef struct packed {
    logic [3:0]  mode;
    logic [1:0]  best_protocol;
    logic [15:0] best_score;
    logic [15:0] second_score;
    logic [3:0]  command;
    logic [1:0]  source_protocol;
    logic [7:0]  frame_byte;
    logic        last_byte;
  } item_t;

  typedef struct packed {
    logic [3:0] destination;
    logic [1:0] message_kind;
    logic [1:0] argument;
  } result_t;

  typedef struct packed {
    logic [1:0]  active_proto;
    logic [1:0]  next_proto;
    logic        exchanging;
    logic        notify_pending;
    logic [15:0] frame_crc;
    logic [11:0] frame_count;
    logic        first_is_header;
    logic [7:0]  tenth_byte;
  } state_t;

  typedef struct packed {
    logic        coordinator;
    logic [15:0] score_threshold;
  } cfg_t;

  // Control port of a protocol, none for unknown numbers
  function automatic logic [3:0] ctrl_dest(input logic [1:0] proto);
    logic [3:0] dest;
    case (proto)
      PROTO_ONE: dest = DEST_P1_CTRL;
      PROTO_TWO: dest = DEST_P2_CTRL;
      default:   dest = DEST_NONE;
    endcase
    return dest;
  endfunction

  function automatic logic [3:0] app_dest(input logic [1:0] proto);
    logic [3:0] dest;
    case (proto)
      PROTO_ONE: dest = DEST_P1_APP;
      PROTO_TWO: dest = DEST_P2_APP;
      default:   dest = DEST_NONE;
    endcase
    return dest;
  endfunction

  function automatic logic [3:0] mac_dest(input logic [1:0] proto);
    logic [3:0] dest;
    case (proto)
      PROTO_ONE: dest = DEST_P1_MAC;
      PROTO_TWO: dest = DEST_P2_MAC;
      default:   dest = DEST_NONE;
    endcase
    return dest;
  endfunction

  // CRC-16/KERMIT over one byte, LSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] crc;
    logic        fb;
    crc = crc_in;
    for (int k = 0; k < 8; k++) begin
      fb  = data[k] ^ crc[0];
      crc = {1'b0, crc[15:1]};
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

endpackage

// File: hdl/msc_event.sv
// ----------------------------------------------------------------------------
// msc_event
// Event decode: next controller state and routing result for one item.
// ----------------------------------------------------------------------------
module msc_event import msc_pkg::*; #(
  parameter logic [11:0] COUNT_LIMIT = 12'd2048
) (
  input  cfg_t    cfg_i,
  input  state_t  state_i,
  input  item_t   item_i,
  output state_t  state_o,
  output result_t result_o
);

  logic signed [16:0] diff;
  logic        [16:0] gap;
  logic        [12:0] frame_len;
  logic               len_ok;
  logic        [1:0]  named_proto;
  result_t            res;

  // Score gap in exact 17-bit arithmetic
  assign diff = 17'(signed'(item_i.best_score)) - 17'(signed'(item_i.second_score));
  assign gap  = diff[16] ? 17'(-diff) : 17'(diff);

  assign frame_len = {1'b0, state_i.frame_count} + 13'd1;
  assign len_ok    = !((frame_len < MIN_FRAME_LEN) && (frame_len != SHORT_FRAME_LEN));

  always_comb begin
    case (state_i.tenth_byte)
      PROTO_ONE_CHAR: named_proto = PROTO_ONE;
      PROTO_TWO_CHAR: named_proto = PROTO_TWO;
      default:        named_proto = PROTO_NONE;
    endcase
  end

  // Decode the event
  always_comb begin
    state_o = state_i;
    res     = '{destination: DEST_NONE, message_kind: KIND_PASS, argument: PROTO_NONE};
    case (item_i.mode)
      MODE_SCORES: begin
        if (!state_i.exchanging && (item_i.best_protocol != state_i.active_proto) &&
            (gap > {1'b0, cfg_i.score_threshold})) begin
          state_o.next_proto = item_i.best_protocol;
          if (cfg_i.coordinator && !state_i.notify_pending) begin
            state_o.notify_pending = 1'b1;
            res = '{destination:  ctrl_dest(state_i.active_proto),
                    message_kind: KIND_SEND_INFO,
                    argument:     item_i.best_protocol};
          end
        end
      end
      MODE_LATENCY: begin
        if (!cfg_i.coordinator && (item_i.command == CMD_LATENCY_SEND)) begin
          res.destination = ctrl_dest(state_i.active_proto);
        end
      end
      MODE_CTRL: begin
        if (item_i.command == CMD_INFO_SENT) begin
          state_o.notify_pending = 1'b0;
          state_o.exchanging     = 1'b1;
          res.destination        = ctrl_dest(state_i.active_proto);
          res.message_kind       = KIND_STOP;
        end else if (item_i.command == CMD_DONE) begin
          state_o.active_proto = state_i.next_proto;
          state_o.exchanging   = 1'b0;
          res = '{destination:  DEST_DECISION,
                  message_kind: KIND_ACTIVE,
                  argument:     state_i.next_proto};
        end
      end
      MODE_HANDOVER: begin
        res.destination = ctrl_dest(state_i.next_proto);
      end
      MODE_APP_DOWN: begin
        if (!state_i.exchanging) begin
          res.destination = app_dest(state_i.active_proto);
        end
      end
      MODE_APP_UP, MODE_MAC_UP: begin
        if (!state_i.exchanging &&
            ((item_i.source_protocol == PROTO_ONE) || (item_i.source_protocol == PROTO_TWO)) &&
            (item_i.source_protocol == state_i.active_proto)) begin
          res.destination = (item_i.mode == MODE_APP_UP) ? DEST_APP : DEST_MAC;
        end
      end
      MODE_FRAME_BYTE: begin
        if (!item_i.last_byte) begin
          // Accumulate one byte of the frame
          if (state_i.frame_count == HEADER_POS) begin
            state_o.first_is_header = (item_i.frame_byte == HEADER_BYTE);
          end
          if (state_i.frame_count == TENTH_POS) begin
            state_o.tenth_byte = item_i.frame_byte;
          end
          state_o.frame_crc = crc_byte(state_i.frame_crc, item_i.frame_byte);
          if (state_i.frame_count < COUNT_LIMIT) begin
            state_o.frame_count = state_i.frame_count + 12'd1;
          end
        end else begin
          // Judge the finished frame
          if (len_ok && (state_i.frame_crc == 16'd0)) begin
            if (state_i.first_is_header && !cfg_i.coordinator &&
                (state_i.tenth_byte != LATENCY_TAG)) begin
              if ((named_proto != PROTO_NONE) && (named_proto != state_i.active_proto)) begin
                state_o.exchanging = 1'b1;
                state_o.next_proto = named_proto;
                res.destination    = ctrl_dest(state_i.active_proto);
                res.message_kind   = KIND_STOP;
              end
            end else if (!state_i.exchanging) begin
              res.destination = mac_dest(state_i.active_proto);
            end
          end
          state_o.frame_crc       = 16'd0;
          state_o.frame_count     = 12'd0;
          state_o.first_is_header = 1'b0;
          state_o.tenth_byte      = 8'd0;
        end
      end
      MODE_TICK: begin
        if (cfg_i.coordinator && !state_i.notify_pending) begin
          res = '{destination:  ctrl_dest(state_i.active_proto),
                  message_kind: KIND_SEND_INFO,
                  argument:     state_i.active_proto};
        end
      end
      default: begin
      end
    endcase
  end

  // No port means no message
  always_comb begin
    result_o = res;
    if (res.destination == DEST_NONE) begin
      result_o.message_kind = KIND_PASS;
      result_o.argument     = PROTO_NONE;
    end
  end

endmodule

// File: hdl/mac_protocol_switch_controller_core.sv
// ----------------------------------------------------------------------------
// mac_protocol_switch_controller_core
// Routes controller events between two MAC protocols and tracks the switch.
// ----------------------------------------------------------------------------
// Usage:
//   Events enter on the s_axis group: tuser carries the event mode, tdata the
//   event fields, tlast marks the final byte of a received frame. Every event
//   yields one result item on the m_axis group (destination and argument in
//   tdata, message kind in tuser).
//   The cfg channel writes the coordinator flag (index 0) and the Q8.8 score
//   threshold (index 1); it is always ready. The user must write it while
//   idle; the block does not enforce this. An accepted item passes the input
//   register, combinational event logic and the result register before it
//   shows on m_axis. Throughput: one item per cycle while m_axis is ready.
//   When the receiver stalls, the result holds and one further item waits in
//   the input register; tready drops only when both are full.
//   Reset returns protocol 1 as active and next, normal state, no pending
//   notification, an empty frame, coordinator 0 and threshold 1280.
// ----------------------------------------------------------------------------
module mac_protocol_switch_controller_core import msc_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Event input
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [1:0] best_protocol, [17:2] best_score, [33:18] second_score,
  // [37:34] command, [39:38] source_protocol, [47:40] frame_byte
  input  logic [47:0] s_axis_tdata_i,
  input  logic        s_axis_tlast_i,  // last_byte
  input  logic [3:0]  s_axis_tuser_i,  // [3:0] mode
  // Routing result
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [3:0] destination, [5:4] argument, [7:6] zero
  output logic [7:0]  m_axis_tdata_o,
  output logic [1:0]  m_axis_tuser_o,  // [1:0] message_kind
  // Configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int          CountLimitInt = (MAX_FRAME_BYTES < 4095) ? MAX_FRAME_BYTES : 4095;
  localparam logic [11:0] CountLimit    = 12'(CountLimitInt);

  cfg_t    cfg_q;
  item_t   item_q;
  logic    item_valid_q;
  result_t result_q;
  logic    result_valid_q;
  state_t  state_q, state_d;
  result_t result_d;
  logic    advance;
  logic    accept;

  // Process the held item when the result register is free or being read
  assign advance         = item_valid_q && (!result_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !item_valid_q || advance;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coordinator     <= 1'b0;
      cfg_q.score_threshold <= THRESHOLD_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_COORDINATOR: cfg_q.coordinator     <= cfg_data_i[0];
        CFG_THRESHOLD:   cfg_q.score_threshold <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      item_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= '{mode:            s_axis_tuser_i,
                  best_protocol:   s_axis_tdata_i[1:0],
                  best_score:      s_axis_tdata_i[17:2],
                  second_score:    s_axis_tdata_i[33:18],
                  command:         s_axis_tdata_i[37:34],
                  source_protocol: s_axis_tdata_i[39:38],
                  frame_byte:      s_axis_tdata_i[47:40],
                  last_byte:       s_axis_tlast_i};
    end
  end

  msc_event #(
    .COUNT_LIMIT (CountLimit)
  ) u_event (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // Controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{active_proto:    PROTO_ONE,
                   next_proto:      PROTO_ONE,
                   exchanging:      1'b0,
                   notify_pending:  1'b0,
                   frame_crc:       16'd0,
                   frame_count:     12'd0,
                   first_is_header: 1'b0,
                   tenth_byte:      8'd0};
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else if (advance) begin
      result_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      result_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid_o = result_valid_q;
  assign m_axis_tdata_o  = {2'b00, result_q.argument, result_q.destination};
  assign m_axis_tuser_o  = result_q.message_kind;

  // Checks
  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (item_valid_q && result_valid_q && !m_axis_tready_i))
    else $error("input stalled while a stage was free");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.frame_count <= CountLimit)
    else $error("frame count above its limit");

  a_none_is_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (result_q.destination == DEST_NONE)) |->
    ((result_q.message_kind == KIND_PASS) && (result_q.argument == PROTO_NONE)))
    else $error("message kind or argument without a destination");

  a_item_consumed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> result_valid_q)
    else $error("processed item produced no result");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the protocol switch controller. A small routing
// model tracks the active and next protocol, the exchange and notification
// flags and the running frame CRC, and predicts the routing result of every
// accepted event. Directed events, sealed and broken frames and weighted
// random events are sent under several register settings, with random
// sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top import msc_pkg::*;;

  localparam int FRAME_BYTES_MAX = 2048;
  localparam int STALL_LIMIT     = 2000;
  localparam int REPORT_MAX      = 10;
  localparam int PHASE_ITEMS     = 100;
  localparam int NUM_PHASES      = 7;

  typedef enum int {STALL_NONE, STALL_COIN, STALL_RARE, STALL_LONG} stall_style_e;

  // Routing model and store of expected routes
  class route_tracker;
    logic        coord;
    logic [15:0] thresh;
    logic [1:0]  act_proto;
    logic [1:0]  nxt_proto;
    logic        exch;
    logic        notify_wait;
    logic [15:0] crc;
    logic [11:0] byte_cnt;
    logic        hdr_seen;
    logic [7:0]  tenth;
    int          cap;
    result_t     routes_due[$];
    int          failures;
    int          checked;

    function new(int frame_cap);
      cap         = frame_cap;
      coord       = 1'b0;
      thresh      = THRESHOLD_RESET;
      act_proto   = PROTO_ONE;
      nxt_proto   = PROTO_ONE;
      exch        = 1'b0;
      notify_wait = 1'b0;
      crc         = '0;
      byte_cnt    = '0;
      hdr_seen    = 1'b0;
      tenth       = '0;
      failures    = 0;
      checked     = 0;
    endfunction

    function void set_reg(logic idx, logic [15:0] val);
      if (idx == CFG_COORDINATOR) begin
        coord = val[0];
      end else begin
        thresh = val;
      end
    endfunction

    // CRC-16/KERMIT, one byte LSB first
    function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
      logic fb;
      for (int k = 0; k < 8; k++) begin
        fb = b[k] ^ c[0];
        c  = c >> 1;
        if (fb) begin
          c = c ^ CRC_POLY;
        end
      end
      return c;
    endfunction

    // Port of protocol one or two, none for any other number
    function logic [3:0] port_of(logic [1:0] proto, logic [3:0] one, logic [3:0] two);
      if (proto == PROTO_ONE) return one;
      if (proto == PROTO_TWO) return two;
      return DEST_NONE;
    endfunction

    function result_t route(logic [3:0] dest, logic [1:0] kind, logic [1:0] arg);
      result_t r;
      r.destination  = dest;
      r.message_kind = (dest == DEST_NONE) ? KIND_PASS : kind;
      r.argument     = (dest == DEST_NONE) ? PROTO_NONE : arg;
      return r;
    endfunction

    function int pending();
      return routes_due.size();
    endfunction

    // Advance the model by one accepted event and queue its route
    function void note_event(item_t it);
      result_t     r;
      int          diff;
      int          gap;
      logic [12:0] len;
      logic [1:0]  p;
      r = route(DEST_NONE, KIND_PASS, PROTO_NONE);
      case (it.mode)
        MODE_SCORES: begin
          if (!exch) begin
            diff = $signed(it.best_score) - $signed(it.second_score);
            gap  = (diff < 0) ? -diff : diff;
            if (it.best_protocol != act_proto && gap > int'({16'd0, thresh})) begin
              nxt_proto = it.best_protocol;
              if (coord && !notify_wait) begin
                notify_wait = 1'b1;
                r = route(port_of(act_proto, DEST_P1_CTRL, DEST_P2_CTRL),
                          KIND_SEND_INFO, nxt_proto);
              end
            end
          end
        end
        MODE_LATENCY: begin
          if (!coord && it.command == CMD_LATENCY_SEND) begin
            r = route(port_of(act_proto, DEST_P1_CTRL, DEST_P2_CTRL), KIND_PASS, PROTO_NONE);
          end
        end
        MODE_CTRL: begin
          if (it.command == CMD_INFO_SENT) begin
            notify_wait = 1'b0;
            exch        = 1'b1;
            r = route(port_of(act_proto, DEST_P1_CTRL, DEST_P2_CTRL), KIND_STOP, PROTO_NONE);
          end else if (it.command == CMD_DONE) begin
            act_proto = nxt_proto;
            exch      = 1'b0;
            r = route(DEST_DECISION, KIND_ACTIVE, act_proto);
          end
        end
        MODE_HANDOVER: begin
          r = route(port_of(nxt_proto, DEST_P1_CTRL, DEST_P2_CTRL), KIND_PASS, PROTO_NONE);
        end
        MODE_APP_DOWN: begin
          if (!exch) begin
            r = route(port_of(act_proto, DEST_P1_APP, DEST_P2_APP), KIND_PASS, PROTO_NONE);
          end
        end
        MODE_APP_UP, MODE_MAC_UP: begin
          if (!exch && (it.source_protocol == PROTO_ONE || it.source_protocol == PROTO_TWO)
              && it.source_protocol == act_proto) begin
            r = route((it.mode == MODE_APP_UP) ? DEST_APP : DEST_MAC, KIND_PASS, PROTO_NONE);
          end
        end
        MODE_FRAME_BYTE: begin
          if (!it.last_byte) begin
            if (byte_cnt == HEADER_POS) hdr_seen = (it.frame_byte == HEADER_BYTE);
            if (byte_cnt == TENTH_POS) tenth = it.frame_byte;
            crc = crc_step(crc, it.frame_byte);
            if (byte_cnt < cap) byte_cnt++;
          end else begin
            len = {1'b0, byte_cnt} + 13'd1;
            if (!(len < MIN_FRAME_LEN && len != SHORT_FRAME_LEN) && crc == '0) begin
              if (hdr_seen && !coord && tenth != LATENCY_TAG) begin
                // Switch frame: the tenth byte names the protocol
                p = (tenth == PROTO_ONE_CHAR) ? PROTO_ONE :
                    (tenth == PROTO_TWO_CHAR) ? PROTO_TWO : PROTO_NONE;
                if (p != PROTO_NONE && p != act_proto) begin
                  exch      = 1'b1;
                  nxt_proto = p;
                  r = route(port_of(act_proto, DEST_P1_CTRL, DEST_P2_CTRL),
                            KIND_STOP, PROTO_NONE);
                end
              end else if (!exch) begin
                r = route(port_of(act_proto, DEST_P1_MAC, DEST_P2_MAC), KIND_PASS, PROTO_NONE);
              end
            end
            crc      = '0;
            byte_cnt = '0;
            hdr_seen = 1'b0;
            tenth    = '0;
          end
        end
        MODE_TICK: begin
          if (coord && !notify_wait) begin
            r = route(port_of(act_proto, DEST_P1_CTRL, DEST_P2_CTRL), KIND_SEND_INFO, act_proto);
          end
        end
        default: begin
        end
      endcase
      routes_due.push_back(r);
    endfunction

    // Compare one result item with the oldest expected route
    function void check_route(result_t got);
      result_t want;
      if (routes_due.size() == 0) begin
        failures++;
        if (failures <= REPORT_MAX) begin
          $display("[%0t] unexpected route: dest %0d kind %0d arg %0d", $realtime,
                   got.destination, got.message_kind, got.argument);
        end
        return;
      end
      want = routes_due.pop_front();
      checked++;
      if (got.destination !== want.destination || got.message_kind !== want.message_kind ||
          got.argument !== want.argument) begin
        failures++;
        if (failures <= REPORT_MAX) begin
          $display("[%0t] route mismatch: expected dest %0d kind %0d arg %0d, got %0d %0d %0d",
                   $realtime, want.destination, want.message_kind, want.argument,
                   got.destination, got.message_kind, got.argument);
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i;
  logic        s_axis_tlast_i;
  logic [3:0]  s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [7:0]  m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [15:0] cfg_data_i;

  route_tracker board;
  int           burst_left;
  int           events_sent;
  int           frame_bytes;
  int           frames_sent;

  mac_protocol_switch_controller_core #(
    .MAX_FRAME_BYTES(FRAME_BYTES_MAX)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Observe handshakes: check results before noting new events
  always @(posedge clk_i) begin
    item_t   it;
    result_t got;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.destination  = m_axis_tdata_o[3:0];
        got.argument     = m_axis_tdata_o[5:4];
        got.message_kind = m_axis_tuser_o;
        board.check_route(got);
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        it.mode            = s_axis_tuser_i;
        it.best_protocol   = s_axis_tdata_i[1:0];
        it.best_score      = s_axis_tdata_i[17:2];
        it.second_score    = s_axis_tdata_i[33:18];
        it.command         = s_axis_tdata_i[37:34];
        it.source_protocol = s_axis_tdata_i[39:38];
        it.frame_byte      = s_axis_tdata_i[47:40];
        it.last_byte       = s_axis_tlast_i;
        board.note_event(it);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        board.set_reg(cfg_index_i, cfg_data_i);
      end
    end
  end

  // Receiver back-pressure in randomly chosen, changing styles
  initial begin : receiver_stalls
    stall_style_e style;
    int           style_left;
    int           run;
    logic         hold_ready;
    m_axis_tready_i = 1'b0;
    style      = STALL_NONE;
    style_left = 0;
    run        = 0;
    hold_ready = 1'b1;
    forever begin
      @(negedge clk_i);
      if (style_left == 0) begin
        style      = stall_style_e'($urandom_range(0, 3));
        style_left = $urandom_range(64, 256);
      end
      style_left--;
      case (style)
        STALL_NONE: m_axis_tready_i <= 1'b1;
        STALL_COIN: m_axis_tready_i <= 1'($urandom_range(0, 1));
        STALL_RARE: m_axis_tready_i <= ($urandom_range(0, 7) != 0);
        default: begin
          if (run == 0) begin
            hold_ready = !hold_ready;
            run        = hold_ready ? $urandom_range(1, 10) : $urandom_range(1, 20);
          end
          run--;
          m_axis_tready_i <= hold_ready;
        end
      endcase
    end
  end

  // Watchdog: end the run when no channel moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("No handshake for %0d cycles, %0d routes outstanding", STALL_LIMIT,
             board.pending());
    $display("Simulation FAILED");
    $finish;
  end

  function automatic item_t random_item();
    item_t it;
    it.mode            = 4'($urandom);
    it.best_protocol   = 2'($urandom);
    it.best_score      = 16'($urandom);
    it.second_score    = 16'($urandom);
    it.command         = 4'($urandom);
    it.source_protocol = 2'($urandom);
    it.frame_byte      = 8'($urandom);
    it.last_byte       = 1'($urandom);
    return it;
  endfunction

  // Send one event; open a random gap when the burst runs out
  task automatic send_event(input item_t it);
    if (burst_left == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {it.frame_byte, it.source_protocol, it.command, it.second_score,
                        it.best_score, it.best_protocol};
    s_axis_tlast_i  <= it.last_byte;
    s_axis_tuser_i  <= it.mode;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
    events_sent++;
  endtask

  task automatic send_op(input logic [3:0] mode, input logic [1:0] proto,
                         input logic [15:0] best, input logic [15:0] second,
                         input logic [3:0] cmd);
    item_t it;
    it                 = random_item();
    it.mode            = mode;
    it.best_protocol   = proto;
    it.source_protocol = proto;
    it.best_score      = best;
    it.second_score    = second;
    it.command         = cmd;
    send_event(it);
  endtask

  // Send a frame of total bytes; a sealed frame carries its CRC before the
  // final byte so that the running CRC comes back to zero
  task automatic send_frame(input int total, input logic [7:0] head, input logic [7:0] tag,
                            input bit seal);
    logic [7:0]  body[$];
    logic [15:0] c;
    item_t       it;
    int          n_crc;
    int          n_free;
    n_crc  = total - 1;
    n_free = (seal && n_crc >= 2) ? n_crc - 2 : n_crc;
    for (int i = 0; i < n_free; i++) begin
      body.push_back((i == 0) ? head : (i == 9) ? tag : 8'($urandom));
    end
    if (n_free != n_crc) begin
      c = '0;
      foreach (body[i]) c = board.crc_step(c, body[i]);
      body.push_back(c[7:0]);
      body.push_back(c[15:8]);
    end
    foreach (body[i]) begin
      it            = random_item();
      it.mode       = MODE_FRAME_BYTE;
      it.frame_byte = body[i];
      it.last_byte  = 1'b0;
      send_event(it);
    end
    it           = random_item();
    it.mode      = MODE_FRAME_BYTE;
    it.last_byte = 1'b1;
    send_event(it);
    frame_bytes += total;
    frames_sent++;
  endtask

  // Hold the sender until every expected route has come back
  task automatic drain_routes();
    s_axis_tvalid_i <= 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [1:0] pick_proto();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return PROTO_ONE;
    if (r < 8) return PROTO_TWO;
    return 2'($urandom);
  endfunction

  // One weighted random event, or a whole frame
  task automatic random_event();
    item_t      it;
    int         pick;
    int         f;
    logic [7:0] head;
    logic [7:0] tag;
    it   = random_item();
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      it.mode          = MODE_SCORES;
      it.best_protocol = pick_proto();
      if ($urandom_range(0, 1) == 0) begin
        // land the gap on or next to the threshold
        it.best_score = it.second_score + board.thresh + 16'($urandom_range(0, 2)) - 16'd1;
      end
      send_event(it);
    end else if (pick < 25) begin
      it.mode = MODE_CTRL;
      f = $urandom_range(0, 9);
      if (f < 5) it.command = CMD_INFO_SENT;
      else if (f < 9) it.command = CMD_DONE;
      send_event(it);
    end else if (pick < 32) begin
      it.mode = MODE_LATENCY;
      if ($urandom_range(0, 9) < 7) it.command = CMD_LATENCY_SEND;
      send_event(it);
    end else if (pick < 38) begin
      it.mode = MODE_HANDOVER;
      send_event(it);
    end else if (pick < 46) begin
      it.mode = MODE_APP_DOWN;
      send_event(it);
    end else if (pick < 58) begin
      it.mode            = ($urandom_range(0, 1) == 0) ? MODE_APP_UP : MODE_MAC_UP;
      it.source_protocol = pick_proto();
      send_event(it);
    end else if (pick < 64) begin
      it.mode = MODE_TICK;
      send_event(it);
    end else if (pick < 68) begin
      it.mode = 4'($urandom_range(MODE_TICK + 1, 15));
      send_event(it);
    end else if (pick < 72) begin
      // stray byte that splits or ends a frame early
      it.mode = MODE_FRAME_BYTE;
      send_event(it);
    end else begin
      head = ($urandom_range(0, 2) != 0) ? HEADER_BYTE : 8'($urandom);
      case ($urandom_range(0, 3))
        0:       tag = PROTO_ONE_CHAR;
        1:       tag = PROTO_TWO_CHAR;
        2:       tag = LATENCY_TAG;
        default: tag = 8'($urandom);
      endcase
      f = $urandom_range(0, 9);
      if (f < 7) begin
        send_frame($urandom_range(13, 24), head, tag, 1'b1);
      end else if (f == 7) begin
        case ($urandom_range(0, 2))
          0:       send_frame(6, head, tag, 1'b1);
          1:       send_frame(11, head, tag, 1'b1);
          default: send_frame(12, head, tag, 1'b1);
        endcase
      end else if (f == 8) begin
        send_frame($urandom_range(1, 12), head, tag, 1'b0);
      end else begin
        send_frame($urandom_range(13, 30), head, tag, 1'b0);
      end
    end
  endtask

  // Main sequence
  initial begin : stimulus
    logic        set_coord[NUM_PHASES];
    logic [15:0] set_thresh[NUM_PHASES];
    int          start;
    int          pause_at;
    bit          paused;
    int          leftover;

    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    s_axis_tuser_i  = '0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = CFG_COORDINATOR;
    cfg_data_i      = '0;
    burst_left      = 0;
    events_sent     = 0;
    frame_bytes     = 0;
    frames_sent     = 0;
    board = new((FRAME_BYTES_MAX < 4095) ? FRAME_BYTES_MAX : 4095);

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: follower node at the reset threshold
    write_reg(CFG_COORDINATOR, 16'd0);
    write_reg(CFG_THRESHOLD, THRESHOLD_RESET);
    send_op(MODE_SCORES, PROTO_TWO, 16'h7FFF, 16'h8000, CMD_DONE);
    send_op(MODE_SCORES, PROTO_ONE, 16'h7FFF, 16'h8000, CMD_DONE);
    send_op(MODE_TICK, PROTO_ONE, 16'h0000, 16'h0000, CMD_DONE);
    send_op(MODE_LATENCY, PROTO_ONE, 16'h0000, 16'h0000, CMD_LATENCY_SEND);
    send_op(MODE_LATENCY, PROTO_ONE, 16'h0000, 16'h0000, CMD_DONE);
    send_op(MODE_HANDOVER, PROTO_ONE, 16'h0000, 16'h0000, CMD_DONE);
    send_op(MODE_APP_DOWN, PROTO_ONE, 16'h0000, 16'h0000, CMD_DONE);
    send_op(MODE_APP_UP, PROTO_ONE, 16'h0000, 16'h0000, CMD_DONE);
    send_op(MODE_MAC_UP, PROTO_TWO, 16'h0000, 16'h0000, CMD_DONE);
    send_op(MODE_MAC_UP, PROTO_ONE, 16'h0000, 16'h0000, CMD_DONE);
    send_op(MODE_APP_UP, PROTO_NONE, 16'h0000, 16'h0000, CMD_DONE);
    send_op(4'hF, PROTO_ONE, 16'hFFFF, 16'hFFFF, CMD_INFO_SENT);
    send_op(MODE_CTRL, PROTO_ONE, 16'h0000, 16'h0000, CMD_INFO_SENT);
    send_op(MODE_APP_DOWN, PROTO_ONE, 16'h0000, 16'h0000, CMD_DONE);
    send_op(MODE_CTRL, PROTO_ONE, 16'h0000, 16'h0000, CMD_DONE);
    send_op(MODE_CTRL, PROTO_ONE, 16'h0000, 16'h0000, CMD_LATENCY_SEND);
    send_frame(14, HEADER_BYTE, PROTO_ONE_CHAR, 1'b1);
    send_op(MODE_CTRL, PROTO_ONE, 16'h0000, 16'h0000, CMD_DONE);
    send_frame(15, HEADER_BYTE, LATENCY_TAG, 1'b1);
    send_frame(6, HEADER_BYTE, 8'h00, 1'b1);
    send_frame(6, 8'h00, 8'h00, 1'b1);
    send_frame(5, 8'h00, 8'h00, 1'b1);
    send_frame(16, HEADER_BYTE, 8'h33, 1'b1);
    send_frame(13, HEADER_BYTE, PROTO_TWO_CHAR, 1'b0);
    drain_routes();

    // Directed: coordinator with zero threshold
    write_reg(CFG_COORDINATOR, 16'd1);
    write_reg(CFG_THRESHOLD, 16'd0);
    send_op(MODE_SCORES, PROTO_ONE, 16'h8000, 16'h8000, CMD_DONE);
    send_op(MODE_SCORES, PROTO_TWO, 16'h0001, 16'h0000, CMD_DONE);
    send_op(MODE_TICK, PROTO_ONE, 16'h0000, 16'h0000, CMD_DONE);
    send_op(MODE_LATENCY, PROTO_ONE, 16'h0000, 16'h0000, CMD_LATENCY_SEND);
    send_op(MODE_CTRL, PROTO_ONE, 16'h0000, 16'h0000, CMD_INFO_SENT);
    send_op(MODE_SCORES, PROTO_ONE, 16'h7FFF, 16'h8000, CMD_DONE);
    send_op(MODE_CTRL, PROTO_ONE, 16'h0000, 16'h0000, CMD_DONE);
    send_op(MODE_TICK, PROTO_ONE, 16'h0000, 16'h0000, CMD_DONE);
    send_frame(14, HEADER_BYTE, PROTO_ONE_CHAR, 1'b1);
    drain_routes();

    // Random phases across register settings, extremes included
    set_coord[0] = 1'b0; set_thresh[0] = THRESHOLD_RESET;
    set_coord[1] = 1'b1; set_thresh[1] = 16'd0;
    set_coord[2] = 1'b0; set_thresh[2] = 16'hFFFF;
    set_coord[3] = 1'b1; set_thresh[3] = 16'hFFFF;
    set_coord[4] = 1'b0; set_thresh[4] = 16'd0;
    set_coord[5] = 1'b1; set_thresh[5] = 16'($urandom);
    set_coord[6] = 1'b0; set_thresh[6] = 16'($urandom_range(0, 4096));
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_reg(CFG_COORDINATOR, {15'd0, set_coord[ph]});
      write_reg(CFG_THRESHOLD, set_thresh[ph]);
      start    = events_sent;
      pause_at = $urandom_range(10, PHASE_ITEMS - 10);
      paused   = 1'b0;
      while (events_sent - start < PHASE_ITEMS) begin
        if (!paused && events_sent - start >= pause_at) begin
          drain_routes();
          paused = 1'b1;
        end
        random_event();
      end
      drain_routes();
    end

    repeat (10) @(posedge clk_i);
    leftover = board.pending();
    if (leftover != 0) begin
      $display("%0d expected routes never arrived", leftover);
    end
    $display("Sent %0d events, %0d of them in %0d frames, over %0d register settings;",
             events_sent, frame_bytes, frames_sent, NUM_PHASES + 2);
    $display("checked %0d routes, %0d failures", board.checked, board.failures + leftover);
    if (board.failures == 0 && leftover == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
